>>> sv/mlbs_pkg.sv
// Package for the modem link bring-up sequencer: event codes, sequencer states,
// command codes, field widths and the command lookup function.
// No dependencies.
package mlbs_pkg;

   // Field widths
   localparam int OpWidth      = 3;
   localparam int MstatWidth   = 3;
   localparam int ByteWidth    = 8;
   localparam int CmdWidth     = 4;
   localparam int FidWidth     = 4;
   localparam int LinkWidth    = 2;
   localparam int TimerWidth   = 16;
   localparam int CsrIdxWidth  = 2;
   localparam int ReqDataWidth = 16;
   localparam int RspDataWidth = 32;

   // Event codes carried with each input transfer
   typedef enum logic [OpWidth-1:0] {
      OP_TICK      = 3'd0,
      OP_MSTATUS   = 3'd1,
      OP_AT_RESP   = 3'd2,
      OP_OTHER     = 3'd3,
      OP_SERVICE   = 3'd4,
      OP_RESTART   = 3'd5,
      OP_MARK_SENT = 3'd6
   } op_type;

   // Modem status codes
   localparam logic [MstatWidth-1:0] MS_ASSOC    = 3'd0;
   localparam logic [MstatWidth-1:0] MS_STARTED  = 3'd1;
   localparam logic [MstatWidth-1:0] MS_DISASSOC = 3'd2;
   localparam logic [MstatWidth-1:0] MS_HW_RESET = 3'd3;
   localparam logic [MstatWidth-1:0] MS_WD_RESET = 3'd4;

   // Commands issued to the modem
   typedef enum logic [CmdWidth-1:0] {
      CMD_NONE = 4'd0,
      CMD_NI   = 4'd1,
      CMD_JV   = 4'd2,
      CMD_JN   = 4'd3,
      CMD_NW   = 4'd4,
      CMD_WR   = 4'd5,
      CMD_FR   = 4'd6,
      CMD_CH   = 4'd7,
      CMD_DB   = 4'd8
   } cmd_type;

   // Link status codes
   typedef enum logic [LinkWidth-1:0] {
      LINK_INIT      = 2'd0,
      LINK_READY     = 2'd1,
      LINK_RESETTING = 2'd2
   } link_type;

   // Configuration register indexes
   localparam logic [CsrIdxWidth-1:0] CSR_CMD_TIMEOUT     = 2'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_RESTART_TIMEOUT = 2'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_STATUS_PERIOD   = 2'd2;

   // Reset values of the configuration registers
   localparam logic [TimerWidth-1:0] CmdTimeoutReset     = 16'd100;
   localparam logic [TimerWidth-1:0] RestartTimeoutReset = 16'd1000;
   localparam logic [TimerWidth-1:0] StatusPeriodReset   = 16'd1000;

   // Sequencer states; send states are even, awaiting states odd
   typedef enum logic [4:0] {
      ST_SEND_NI1 = 5'd0,
      ST_NI_SENT1 = 5'd1,
      ST_SEND_JV  = 5'd2,
      ST_JV_SENT  = 5'd3,
      ST_SEND_JN  = 5'd4,
      ST_JN_SENT  = 5'd5,
      ST_SEND_NW  = 5'd6,
      ST_NW_SENT  = 5'd7,
      ST_SEND_WR  = 5'd8,
      ST_WR_SENT  = 5'd9,
      ST_SEND_NI2 = 5'd10,
      ST_NI_SENT2 = 5'd11,
      ST_SEND_FR  = 5'd12,
      ST_FR_SENT  = 5'd13,
      ST_SEND_CH  = 5'd14,
      ST_CH_SENT  = 5'd15,
      ST_SEND_DB  = 5'd16,
      ST_DB_SENT  = 5'd17,
      ST_RESET    = 5'd18,
      ST_READY    = 5'd19
   } seq_type;

   // Command for a send state; CMD_NONE for any other state
   function automatic cmd_type cmd_of(seq_type s);
      cmd_type c;
      case (s)
         ST_SEND_NI1: c = CMD_NI;
         ST_SEND_JV:  c = CMD_JV;
         ST_SEND_JN:  c = CMD_JN;
         ST_SEND_NW:  c = CMD_NW;
         ST_SEND_WR:  c = CMD_WR;
         ST_SEND_NI2: c = CMD_NI;
         ST_SEND_FR:  c = CMD_FR;
         ST_SEND_CH:  c = CMD_CH;
         ST_SEND_DB:  c = CMD_DB;
         default:     c = CMD_NONE;
      endcase
      return c;
   endfunction

   // Link status reported for a state
   function automatic link_type link_of(seq_type s);
      link_type l;
      case (s)
         ST_SEND_NI1: l = LINK_INIT;
         ST_SEND_CH,
         ST_CH_SENT,
         ST_SEND_DB,
         ST_DB_SENT,
         ST_READY:    l = LINK_READY;
         default:     l = LINK_RESETTING;
      endcase
      return l;
   endfunction

endpackage

>>> sv/modem_link_bringup_sequencer.sv
// Modem link bring-up sequencer: stream in events, stream out one result each.
// Depends on mlbs_pkg.
//
// Each accepted event yields exactly one result transfer. The block takes one
// event per clock cycle when the result side keeps up; an event waits in the
// input register and is evaluated against the sequencer state on its way into
// the result register, which holds the result until it is taken. The state
// update is a single combinational pass per event, which sets the one-per-cycle
// figure. Configuration writes take effect on the next cycle and are meant to
// happen while no event is in flight.
module modem_link_bringup_sequencer
   import mlbs_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   // Event input
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [ReqDataWidth-1:0]  req_tdata,  // modem_status[2:0], resp_byte[10:3], zero
   input  logic [OpWidth-1:0]       req_tuser,  // op[2:0]
   // Result output
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RspDataWidth-1:0]  rsp_tdata,  // send_cmd[3:0], frame_id[7:4],
                                                // cmd_arg[8], link_state[10:9],
                                                // op_channel[18:11], rssi[26:19], zero
   // Configuration writes
   input  logic                     csr_wr_en,
   input  logic [CsrIdxWidth-1:0]   csr_index,
   input  logic [TimerWidth-1:0]    csr_wdata
);

   // Configuration registers
   logic [TimerWidth-1:0] cmd_timeout_ff, restart_timeout_ff, status_period_ff;

   // Input register
   logic                  in_valid_ff;
   logic [OpWidth-1:0]    in_op_ff;
   logic [MstatWidth-1:0] in_mstat_ff;
   logic [ByteWidth-1:0]  in_byte_ff;

   // Sequencer state
   seq_type               seq_ff, seq_in;
   logic [TimerWidth-1:0] cmd_timer_ff, cmd_timer_in;
   logic [TimerWidth-1:0] status_timer_ff, status_timer_in;
   logic [ByteWidth-1:0]  channel_ff, channel_in;
   logic [ByteWidth-1:0]  strength_ff, strength_in;

   // Result register
   logic                  out_valid_ff;
   cmd_type               out_cmd_ff, cmd_in;
   logic [FidWidth-1:0]   out_fid_ff, fid_in;
   logic                  out_arg_ff, arg_in;
   link_type              out_link_ff;

   logic                  out_free;
   logic                  advance;
   logic [TimerWidth-1:0] cmd_timer_dec;

   // Handshake: result stage frees when empty or drained, input moves when it can
   assign out_free   = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'd0, strength_ff, channel_ff, out_link_ff, out_arg_ff,
                        out_fid_ff, out_cmd_ff};

   // Configuration writes; indexes beyond the list are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_timeout_ff     <= CmdTimeoutReset;
         restart_timeout_ff <= RestartTimeoutReset;
         status_period_ff   <= StatusPeriodReset;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_CMD_TIMEOUT:     cmd_timeout_ff     <= csr_wdata;
            CSR_RESTART_TIMEOUT: restart_timeout_ff <= csr_wdata;
            CSR_STATUS_PERIOD:   status_period_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Capture an input transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_op_ff    <= req_tuser;
         in_mstat_ff <= req_tdata[2:0];
         in_byte_ff  <= req_tdata[10:3];
      end
   end

   assign cmd_timer_dec = cmd_timer_ff - 16'd1;

   // Evaluate one event against the sequencer state
   always_comb begin
      seq_in          = seq_ff;
      cmd_timer_in    = cmd_timer_ff;
      status_timer_in = status_timer_ff;
      channel_in      = channel_ff;
      strength_in     = strength_ff;
      cmd_in          = CMD_NONE;
      fid_in          = '0;
      arg_in          = 1'b0;

      case (op_type'(in_op_ff))
         OP_TICK: begin
            // Count down the command timeout, restart on expiry
            if (cmd_timer_ff != '0) begin
               cmd_timer_in = cmd_timer_dec;
               if (cmd_timer_dec == '0) begin
                  seq_in = ST_SEND_NI1;
               end
            end
            // Periodic strength read
            if (status_timer_ff != '0) begin
               if (status_timer_ff == 16'd1) begin
                  seq_in          = ST_SEND_DB;
                  status_timer_in = '0;
               end else begin
                  status_timer_in = status_timer_ff - 16'd1;
               end
            end
         end
         OP_MSTATUS: begin
            if (in_mstat_ff == MS_ASSOC || in_mstat_ff == MS_STARTED) begin
               seq_in       = ST_SEND_CH;
               cmd_timer_in = '0;
            end else if (in_mstat_ff == MS_DISASSOC || in_mstat_ff == MS_HW_RESET ||
                         in_mstat_ff == MS_WD_RESET) begin
               seq_in          = ST_RESET;
               cmd_timer_in    = '0;
               status_timer_in = '0;
            end
         end
         OP_AT_RESP: begin
            case (seq_ff)
               ST_NI_SENT1, ST_JV_SENT, ST_JN_SENT,
               ST_NW_SENT, ST_WR_SENT, ST_NI_SENT2: begin
                  seq_in       = seq_type'(seq_ff + 5'd1);
                  cmd_timer_in = '0;
               end
               ST_CH_SENT: begin
                  channel_in   = in_byte_ff;
                  seq_in       = ST_SEND_DB;
                  cmd_timer_in = '0;
               end
               ST_DB_SENT: begin
                  strength_in     = in_byte_ff;
                  seq_in          = ST_READY;
                  cmd_timer_in    = '0;
                  status_timer_in = status_period_ff;
               end
               default: ;
            endcase
         end
         OP_SERVICE: begin
            // Issue the command of a send state and arm its timeout
            if (seq_ff <= ST_SEND_DB && !seq_ff[0]) begin
               cmd_in       = cmd_of(seq_ff);
               fid_in       = FidWidth'(seq_ff[4:1]) + 4'd1;
               arg_in       = (seq_ff == ST_SEND_JV) || (seq_ff == ST_SEND_JN) ||
                              (seq_ff == ST_SEND_NW);
               cmd_timer_in = (seq_ff == ST_SEND_FR) ? restart_timeout_ff : cmd_timeout_ff;
               seq_in       = seq_type'(seq_ff + 5'd1);
            end
         end
         OP_RESTART:   seq_in = ST_SEND_NI1;
         OP_MARK_SENT: seq_in = ST_NI_SENT1;
         default: ;
      endcase
   end

   // Commit state when an event moves into the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff          <= ST_SEND_NI1;
         cmd_timer_ff    <= '0;
         status_timer_ff <= '0;
         channel_ff      <= '0;
         strength_ff     <= '0;
      end else if (advance) begin
         seq_ff          <= seq_in;
         cmd_timer_ff    <= cmd_timer_in;
         status_timer_ff <= status_timer_in;
         channel_ff      <= channel_in;
         strength_ff     <= strength_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_cmd_ff  <= cmd_in;
         out_fid_ff  <= fid_in;
         out_arg_ff  <= arg_in;
         out_link_ff <= link_of(seq_in);
      end
   end

endmodule
